// ===== rtl/ptrf_pkg.sv =====
// Shared constants, types and the arctangent table of the path point transform.
package ptrf_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRACTION_BITS = 16;
  localparam int ATAN_ENTRIES  = 25;
  localparam int NSTAGE = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int CNTW   = (NSTAGE > 1) ? $clog2(NSTAGE) : 1;

  // Trig width, difference width, product width and sum width of the front part.
  localparam int TW = FRACTION_BITS + 2;
  localparam int DW = 33;
  localparam int PW = DW + TW;
  localparam int SW = PW + 1;

  // Vector width of the back part: normalised magnitude below 2^41 plus CORDIC growth.
  localparam int VW   = 45;
  localparam int NORM = 6;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic [31:0]        ANGLE_PI = 32'h8000_0000;

  typedef enum logic [1:0] {
    REG_ROBOT_X       = 2'd0,
    REG_ROBOT_Y       = 2'd1,
    REG_ROBOT_HEADING = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic                 busy;
    logic signed [TW-1:0] cosine;
    logic signed [TW-1:0] sine;
  } trig_t;

  typedef struct packed {
    logic [31:0] lx;
    logic [31:0] ly;
    logic        first;
  } ent_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic [31:0]          z;
    logic [31:0]          lx;
    logic [31:0]          ly;
    logic                 zero;
  } vec_t;

  function automatic logic [31:0] atan_angle(input int i);
    logic [31:0] a;
    case (i)
      0:  a = 32'd536870912;
      1:  a = 32'd316933406;
      2:  a = 32'd167458907;
      3:  a = 32'd85004756;
      4:  a = 32'd42667331;
      5:  a = 32'd21354465;
      6:  a = 32'd10679838;
      7:  a = 32'd5340245;
      8:  a = 32'd2670163;
      9:  a = 32'd1335087;
      10: a = 32'd667544;
      11: a = 32'd333772;
      12: a = 32'd166886;
      13: a = 32'd83443;
      14: a = 32'd41722;
      15: a = 32'd20861;
      16: a = 32'd10430;
      17: a = 32'd5215;
      18: a = 32'd2608;
      19: a = 32'd1304;
      20: a = 32'd652;
      21: a = 32'd326;
      22: a = 32'd163;
      23: a = 32'd81;
      24: a = 32'd41;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

  function automatic logic [VW-1:0] vabs(input logic signed [VW-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

endpackage

// ===== rtl/ptrf_trig.sv =====
// Iterative rotation CORDIC that caches the cosine and sine of the robot heading.
module ptrf_trig import ptrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        hd_we_i,
  input  logic [15:0] hd_i,
  output trig_t       trig_o
);

  logic                   busy_q;
  logic [CNTW-1:0]        cnt_q;
  logic signed [33:0]     x_q, y_q, x_n, y_n, xr, yr;
  logic signed [31:0]     z_q, z_n, z0;
  logic signed [TW-1:0]   cos_q, sin_q;

  always_comb begin
    if (z_q >= 0) begin
      x_n = x_q - (y_q >>> cnt_q);
      y_n = y_q + (x_q >>> cnt_q);
      z_n = z_q - $signed(atan_angle(int'(cnt_q)));
    end else begin
      x_n = x_q + (y_q >>> cnt_q);
      y_n = y_q - (x_q >>> cnt_q);
      z_n = z_q + $signed(atan_angle(int'(cnt_q)));
    end
    xr = x_n + (34'sd1 <<< (29 - FRACTION_BITS));
    yr = y_n + (34'sd1 <<< (29 - FRACTION_BITS));
    z0 = $signed({hd_i, 16'h0000});
  end

  // Reset starts a pass for heading zero so the cached values are valid afterwards.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      x_q    <= GAIN_Q30;
      y_q    <= '0;
      z_q    <= '0;
      cos_q  <= '0;
      sin_q  <= '0;
    end else if (hd_we_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      y_q    <= '0;
      // Beyond a quarter turn the start vector is flipped and the angle moved by pi.
      if (z0 > 32'sh4000_0000 || z0 < -32'sh4000_0000) begin
        x_q <= -GAIN_Q30;
        z_q <= {~z0[31], z0[30:0]};
      end else begin
        x_q <= GAIN_Q30;
        z_q <= z0;
      end
    end else if (busy_q) begin
      x_q   <= x_n;
      y_q   <= y_n;
      z_q   <= z_n;
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNTW'(NSTAGE - 1)) begin
        busy_q <= 1'b0;
        cos_q  <= TW'(xr >>> (30 - FRACTION_BITS));
        sin_q  <= TW'(yr >>> (30 - FRACTION_BITS));
      end
    end
  end

  assign trig_o.busy   = busy_q;
  assign trig_o.cosine = cos_q;
  assign trig_o.sine   = sin_q;

endmodule

// ===== rtl/ptrf_front.sv =====
// Front part: position offset, rotation by minus the heading and saturation.
module ptrf_front import ptrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic        first_point_i,
  input  logic [31:0] robot_x_i,
  input  logic [31:0] robot_y_i,
  input  trig_t       trig_i,
  input  logic        q_full_i,
  output logic        push_o,
  output ent_t        ent_o
);

  localparam logic signed [SW-1:0] HALF = SW'(1) << (FRACTION_BITS - 1);

  logic                 en;
  logic                 v1_q, v2_q, v3_q;
  logic                 f1_q, f2_q;
  logic signed [DW-1:0] dx_q, dy_q;
  logic signed [TW-1:0] c, s;
  logic signed [PW-1:0] pxc_q, pys_q, pyc_q, pxs_q;
  logic signed [PW-1:0] pxc, pys, pyc, pxs;
  logic signed [SW-1:0] sx, sy, hx, hy;
  ent_t                 ent_q, ent_d;

  assign en         = !(v3_q && q_full_i);
  assign in_stall_o = trig_i.busy || !en;
  assign push_o     = v3_q && !q_full_i;
  assign ent_o      = ent_q;

  assign c   = trig_i.cosine;
  assign s   = trig_i.sine;
  assign pxc = dx_q * c;
  assign pys = dy_q * s;
  assign pyc = dy_q * c;
  assign pxs = dx_q * s;

  always_comb begin
    sx = SW'(pxc_q) + SW'(pys_q) + HALF;
    sy = SW'(pyc_q) - SW'(pxs_q) + HALF;
    hx = sx >>> FRACTION_BITS;
    hy = sy >>> FRACTION_BITS;
    // Clamp when the sign bit of a 32-bit word and the bits above it disagree.
    if (hx[SW-1:31] != {(SW-31){hx[SW-1]}}) begin
      ent_d.lx = hx[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      ent_d.lx = hx[31:0];
    end
    if (hy[SW-1:31] != {(SW-31){hy[SW-1]}}) begin
      ent_d.ly = hy[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      ent_d.ly = hy[31:0];
    end
    ent_d.first = f2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i && !trig_i.busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q  <= $signed({point_x_i[31], point_x_i}) - $signed({robot_x_i[31], robot_x_i});
      dy_q  <= $signed({point_y_i[31], point_y_i}) - $signed({robot_y_i[31], robot_y_i});
      f1_q  <= first_point_i;
      pxc_q <= pxc;
      pys_q <= pys;
      pyc_q <= pyc;
      pxs_q <= pxs;
      f2_q  <= f1_q;
      ent_q <= ent_d;
    end
  end

endmodule

// ===== rtl/ptrf_queue.sv =====
// Short queue of transformed points between the front and the back part.
module ptrf_queue import ptrf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  ent_t ent_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output ent_t ent_o
);

  ent_t           mem_q [QDEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QAW:0]   cnt_q;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign ent_o   = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(push_i) - (QAW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= ent_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAW+1)'(QDEPTH)) else $error("queue count beyond depth");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0) else $error("queue read while empty");
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> !full_o) else $error("queue written while full");

endmodule

// ===== rtl/ptrf_back.sv =====
// Back part: step vector, normalisation, pipelined vectoring CORDIC and output register.
module ptrf_back import ptrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  ent_t        q_ent_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] local_x_o,
  output logic [31:0] local_y_o,
  output logic [15:0] local_heading_o
);

  // Stage 0 forms the step, then normalisation, the pi flip, CORDIC and output.
  localparam int PRE = NORM + 1;
  localparam int ROT = PRE + 1;
  localparam int NB  = ROT + NSTAGE + 1;

  function automatic vec_t f_norm(input vec_t v, input int sh);
    vec_t r;
    logic [VW-1:0] m;
    r = v;
    m = vabs(v.x) | vabs(v.y);
    if (m < (VW'(1) << (41 - sh))) begin
      r.x = v.x <<< sh;
      r.y = v.y <<< sh;
    end
    return r;
  endfunction

  function automatic vec_t f_pre(input vec_t v);
    vec_t r;
    r = v;
    if (v.x < 0) begin
      r.x = -v.x;
      r.y = -v.y;
      r.z = ANGLE_PI;
    end else begin
      r.z = '0;
    end
    return r;
  endfunction

  function automatic vec_t f_rot(input vec_t v, input int i);
    vec_t r;
    r = v;
    if (v.y >= 0) begin
      r.x = v.x + (v.y >>> i);
      r.y = v.y - (v.x >>> i);
      r.z = v.z + atan_angle(i);
    end else begin
      r.x = v.x - (v.y >>> i);
      r.y = v.y + (v.x >>> i);
      r.z = v.z - atan_angle(i);
    end
    return r;
  endfunction

  function automatic vec_t f_out(input vec_t v);
    vec_t r;
    logic [31:0] zr;
    r  = v;
    zr = v.z + 32'd32768;
    r.z = v.zero ? 32'd0 : {16'h0000, zr[31:16]};
    return r;
  endfunction

  logic          en;
  logic [NB-1:0] v_q;
  vec_t          st_q [NB];
  vec_t          nxt  [NB];
  logic [31:0]   prev_x_q, prev_y_q;
  vec_t          s0;

  assign en    = !(v_q[NB-1] && out_stall_i);
  assign pop_o = q_valid_i && en;

  always_comb begin
    s0.lx = q_ent_i.lx;
    s0.ly = q_ent_i.ly;
    s0.z  = '0;
    if (q_ent_i.first) begin
      s0.x = VW'($signed(q_ent_i.lx));
      s0.y = VW'($signed(q_ent_i.ly));
    end else begin
      s0.x = VW'($signed(q_ent_i.lx)) - VW'($signed(prev_x_q));
      s0.y = VW'($signed(q_ent_i.ly)) - VW'($signed(prev_y_q));
    end
    s0.zero = (s0.x == '0) && (s0.y == '0);
  end

  assign nxt[0] = s0;

  for (genvar k = 0; k < NORM; k++) begin : g_norm
    assign nxt[k+1] = f_norm(st_q[k], 32 >> k);
  end

  assign nxt[PRE] = f_pre(st_q[PRE-1]);

  for (genvar i = 0; i < NSTAGE; i++) begin : g_rot
    assign nxt[ROT+i] = f_rot(st_q[ROT+i-1], i);
  end

  assign nxt[NB-1] = f_out(st_q[NB-2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q      <= '0;
      prev_x_q <= '0;
      prev_y_q <= '0;
    end else begin
      if (en) v_q <= {v_q[NB-2:0], q_valid_i};
      // The previous point follows queue order, so it is taken at the read.
      if (pop_o) begin
        prev_x_q <= q_ent_i.lx;
        prev_y_q <= q_ent_i.ly;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NB; k++) begin
        st_q[k] <= nxt[k];
      end
    end
  end

  assign out_valid_o     = v_q[NB-1];
  assign local_x_o       = st_q[NB-1].lx;
  assign local_y_o       = st_q[NB-1].ly;
  assign local_heading_o = st_q[NB-1].z[15:0];

endmodule

// ===== rtl/path_to_robot_frame_transform.sv =====
// Top level of the path point to robot frame transform.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   point_x_i, point_y_i, first_point_i
//   out      output     out_valid_o / out_stall_i local_x_o, local_y_o, local_heading_o
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One point per cycle is taken while no heading pass runs and the queue is not full;
// there are 3 front stages, one queue stage and 9 + CORDIC stages back stages (25
// with 16 stages).
// A heading write starts the heading sine and cosine sequencer, one CORDIC step a
// cycle, and in_stall_o stays high and cfg_ready_o low until the pass is done.
// After reset the same pass runs for heading zero before the first point.
// A stalled output freezes the back pipeline; the four-entry queue lets the front go on.
module path_to_robot_frame_transform import ptrf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] point_x_i,
  input  logic [31:0] point_y_i,
  input  logic        first_point_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] local_x_o,
  output logic [31:0] local_y_o,
  output logic [15:0] local_heading_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] robot_x_q, robot_y_q;
  logic        cfg_we, hd_we;
  trig_t       trig;
  logic        q_full, q_valid, push, pop;
  ent_t        ent_in, ent_out;

  assign cfg_ready_o = !trig.busy;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_comb begin
    hd_we = 1'b0;
    unique case (cfg_index_i)
      REG_ROBOT_HEADING: hd_we = cfg_we;
      default:           hd_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      robot_x_q <= '0;
      robot_y_q <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_ROBOT_X: robot_x_q <= cfg_data_i;
        REG_ROBOT_Y: robot_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ptrf_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .hd_we_i (hd_we),
    .hd_i    (cfg_data_i[15:0]),
    .trig_o  (trig)
  );

  ptrf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .first_point_i (first_point_i),
    .robot_x_i     (robot_x_q),
    .robot_y_i     (robot_y_q),
    .trig_i        (trig),
    .q_full_i      (q_full),
    .push_o        (push),
    .ent_o         (ent_in)
  );

  ptrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ent_i   (ent_in),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .ent_o   (ent_out)
  );

  ptrf_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_ent_i         (ent_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .local_x_o       (local_x_o),
    .local_y_o       (local_y_o),
    .local_heading_o (local_heading_o)
  );

endmodule
